// ===== rtl/acfb_pkg.sv =====
// ----------------------------------------------------------------------------
// acfb_pkg
// Shared widths, frame layout constants and the CRC-16 (poly 0x1021) step
// function for the attitude command frame builder.
// ----------------------------------------------------------------------------
package acfb_pkg;

	localparam int AngleW    = 10;
	localparam int ScaledW   = 16;
	localparam int ByteW     = 8;
	localparam int CrcW      = 16;
	localparam int FrameLen  = 14;
	localparam int HeaderLen = 8;
	localparam int PosW      = $clog2(FrameLen);

	localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

	typedef logic [ByteW-1:0]   byte_t;
	typedef logic [CrcW-1:0]    crc_t;
	typedef logic [ScaledW-1:0] scaled_t;
	typedef logic [PosW-1:0]    pos_t;

	// fixed set-attitude header
	localparam byte_t FrameHeader [HeaderLen] = '{
		8'h55, 8'h66, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h0E
	};

	// byte positions within the frame
	localparam pos_t PosHdrLast = pos_t'(HeaderLen - 1);
	localparam pos_t PosYawLo   = pos_t'(8);
	localparam pos_t PosYawHi   = pos_t'(9);
	localparam pos_t PosPitLo   = pos_t'(10);
	localparam pos_t PosPitHi   = pos_t'(11);
	localparam pos_t PosCrcLo   = pos_t'(12);
	localparam pos_t PosCrcHi   = pos_t'(FrameLen - 1);

	// one byte through the crc, msb first, no reflection
	function automatic crc_t crc_byte(input crc_t crc, input byte_t b);
		crc_t c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < ByteW; i++) begin
			if (c[CrcW-1]) begin
				c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[CrcW-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// crc of the fixed header, folded at elaboration
	function automatic crc_t crc_header();
		crc_t c;
		c = '0;
		for (int k = 0; k < HeaderLen; k++) begin
			c = crc_byte(c, FrameHeader[k]);
		end
		return c;
	endfunction

	localparam crc_t HeaderCrc = crc_header();

endpackage

// ===== rtl/acfb_in_if.sv =====
// ----------------------------------------------------------------------------
// acfb_in_if
// Request channel carrying one yaw / pitch angle pair per request.
// ----------------------------------------------------------------------------
interface acfb_in_if;
	import acfb_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [AngleW-1:0] yaw_degrees;
	logic signed [AngleW-1:0] pitch_degrees;

	modport source (output valid, output yaw_degrees, output pitch_degrees, input ready);
	modport sink   (input valid, input yaw_degrees, input pitch_degrees, output ready);

endinterface

// ===== rtl/acfb_out_if.sv =====
// ----------------------------------------------------------------------------
// acfb_out_if
// Byte channel carrying the command frame, one byte per request.
// ----------------------------------------------------------------------------
interface acfb_out_if;
	import acfb_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] frame_byte;
	logic             last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink   (input valid, input frame_byte, input last_byte, output ready);

endinterface

// ===== rtl/attitude_command_frame_builder.sv =====
// ----------------------------------------------------------------------------
// attitude_command_frame_builder
// Turns a yaw / pitch pair into a 14-byte set-attitude frame with CRC-16.
// ----------------------------------------------------------------------------
// usage:
//   in_ch  takes one request per angle pair (yaw_degrees, pitch_degrees,
//          whole degrees, signed 10 bit); each angle is scaled by ten
//   out_ch gives 14 requests per pair: header 55 66 01 04 00 00 00 0E,
//          yaw lo/hi, pitch lo/hi, crc lo/hi; last_byte marks the crc hi byte
// pipeline: a pair passes the scale stage, four crc byte stages, then the
//   serializer before its first byte is valid
// throughput: one pair per frame, set by the byte serializer that sends
//   one byte per cycle while out_ch.ready is high; up to five more pairs
//   queue in the pipeline, one per cycle, while a frame is being sent
// reset: arst_n clears all valid bits and the serializer; no frame is out
// stall: when out_ch.ready is low the current byte holds, the pipeline
//   fills and then in_ch.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module attitude_command_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	acfb_in_if.sink    in_ch,
	acfb_out_if.source out_ch
);
	import acfb_pkg::*;

	// pipeline valid bits and stage readiness
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// payload per stage
	scaled_t yaw_s1, yaw_s2, yaw_s3, yaw_s4, yaw_s5;
	scaled_t pitch_s1, pitch_s2, pitch_s3, pitch_s4, pitch_s5;
	crc_t    crc_s2, crc_s3, crc_s4, crc_s5;

	// serializer
	logic    busy_q;
	pos_t    pos_q;
	scaled_t yaw_q;
	scaled_t pitch_q;
	crc_t    crc_q;
	logic    ser_ready;
	logic    ser_last;
	logic    ser_load;

	scaled_t yaw_ext, pitch_ext;
	scaled_t yaw_scaled, pitch_scaled;
	byte_t   byte_mux;

	// x*10 = x*8 + x*2 on the sign-extended angle
	assign yaw_ext      = scaled_t'(in_ch.yaw_degrees);
	assign pitch_ext    = scaled_t'(in_ch.pitch_degrees);
	assign yaw_scaled   = {yaw_ext[ScaledW-4:0], 3'b000} + {yaw_ext[ScaledW-2:0], 1'b0};
	assign pitch_scaled = {pitch_ext[ScaledW-4:0], 3'b000} + {pitch_ext[ScaledW-2:0], 1'b0};

	// serializer can take a new frame when idle or on the final byte handoff
	assign ser_last  = (pos_q == PosCrcHi);
	assign ser_ready = !busy_q || (out_ch.ready && ser_last);
	assign ser_load  = valid_s5 && ser_ready;

	// ready chain, back to front
	assign rdy_s5      = !valid_s5 || ser_ready;
	assign rdy_s4      = !valid_s4 || rdy_s5;
	assign rdy_s3      = !valid_s3 || rdy_s4;
	assign rdy_s2      = !valid_s2 || rdy_s3;
	assign rdy_s1      = !valid_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_ch.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	// payload: scale, then the crc one angle byte per stage
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			yaw_s1   <= yaw_scaled;
			pitch_s1 <= pitch_scaled;
		end
		if (rdy_s2) begin
			yaw_s2   <= yaw_s1;
			pitch_s2 <= pitch_s1;
			crc_s2   <= crc_byte(HeaderCrc, yaw_s1[ByteW-1:0]);
		end
		if (rdy_s3) begin
			yaw_s3   <= yaw_s2;
			pitch_s3 <= pitch_s2;
			crc_s3   <= crc_byte(crc_s2, yaw_s2[ScaledW-1:ByteW]);
		end
		if (rdy_s4) begin
			yaw_s4   <= yaw_s3;
			pitch_s4 <= pitch_s3;
			crc_s4   <= crc_byte(crc_s3, pitch_s3[ByteW-1:0]);
		end
		if (rdy_s5) begin
			yaw_s5   <= yaw_s4;
			pitch_s5 <= pitch_s4;
			crc_s5   <= crc_byte(crc_s4, pitch_s4[ScaledW-1:ByteW]);
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (ser_load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (busy_q && out_ch.ready) begin
				if (ser_last) begin
					busy_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					pos_q <= pos_q + pos_t'(1);
				end
			end
		end
	end

	// serializer frame hold
	always_ff @(posedge clk) begin
		if (ser_load) begin
			yaw_q   <= yaw_s5;
			pitch_q <= pitch_s5;
			crc_q   <= crc_s5;
		end
	end

	// byte select by frame position
	always_comb begin
		unique case (pos_q)
			PosYawLo: byte_mux = yaw_q[ByteW-1:0];
			PosYawHi: byte_mux = yaw_q[ScaledW-1:ByteW];
			PosPitLo: byte_mux = pitch_q[ByteW-1:0];
			PosPitHi: byte_mux = pitch_q[ScaledW-1:ByteW];
			PosCrcLo: byte_mux = crc_q[ByteW-1:0];
			PosCrcHi: byte_mux = crc_q[CrcW-1:ByteW];
			default: begin
				if (pos_q <= PosHdrLast) begin
					byte_mux = FrameHeader[pos_q[$clog2(HeaderLen)-1:0]];
				end else begin
					byte_mux = '0;
				end
			end
		endcase
	end

	assign out_ch.valid      = busy_q;
	assign out_ch.frame_byte = byte_mux;
	assign out_ch.last_byte  = ser_last;

endmodule

// ===== sim/attitude_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_frame_checker
// Watches both channels of the frame builder, works out the 14 bytes due for
// every accepted angle pair and compares each sent byte with the oldest one.
// ----------------------------------------------------------------------------
module attitude_frame_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [acfb_pkg::AngleW-1:0] yaw_degrees,
	input  logic signed [acfb_pkg::AngleW-1:0] pitch_degrees,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  acfb_pkg::byte_t                   frame_byte,
	input  logic                              last_byte,
	output int                                bytes_due,
	output int                                fail_count
);
	import acfb_pkg::*;

	localparam int          AngleScale = 10;
	localparam logic [15:0] FramePoly  = 16'h1021;

	localparam byte_t SetAttitudeHeader [8] = '{
		8'h55, 8'h66, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h0E
	};

	typedef struct packed {
		byte_t data;
		logic  last;
	} due_byte_t;

	due_byte_t due_bytes [$];
	int        fails      = 0;
	longint    bytes_seen = 0;

	assign fail_count = fails;

	// whole degrees to tenths, two's complement at 16 bits
	function automatic scaled_t tenths_of(input logic signed [AngleW-1:0] deg);
		int whole;
		whole = deg;
		return scaled_t'(whole * AngleScale);
	endfunction

	// xmodem crc, one bit at a time, msb first
	function automatic crc_t crc_shift_in(input crc_t crc, input byte_t b);
		crc_t c;
		c = crc;
		for (int i = ByteW - 1; i >= 0; i--) begin
			if (c[CrcW-1] ^ b[i]) begin
				c = {c[CrcW-2:0], 1'b0} ^ FramePoly;
			end else begin
				c = {c[CrcW-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	task automatic predict_attitude_frame(input logic signed [AngleW-1:0] yaw,
	                                      input logic signed [AngleW-1:0] pitch);
		byte_t     frame [FrameLen];
		scaled_t   yaw_tenths;
		scaled_t   pitch_tenths;
		crc_t      crc;
		due_byte_t entry;
		for (int k = 0; k < 8; k++) begin
			frame[k] = SetAttitudeHeader[k];
		end
		yaw_tenths   = tenths_of(yaw);
		pitch_tenths = tenths_of(pitch);
		frame[8]  = yaw_tenths[7:0];
		frame[9]  = yaw_tenths[15:8];
		frame[10] = pitch_tenths[7:0];
		frame[11] = pitch_tenths[15:8];
		crc = '0;
		for (int k = 0; k < 12; k++) begin
			crc = crc_shift_in(crc, frame[k]);
		end
		frame[12] = crc[7:0];
		frame[13] = crc[15:8];
		for (int k = 0; k < FrameLen; k++) begin
			entry.data = frame[k];
			entry.last = (k == FrameLen - 1);
			due_bytes  = {due_bytes, entry};
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] byte %0d: %s", $realtime, bytes_seen, msg);
		fails++;
	endtask

	always @(posedge clk) begin
		due_byte_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h with no frame due", frame_byte));
				end else begin
					want = due_bytes.pop_front();
					if (frame_byte !== want.data) begin
						report_mismatch($sformatf("frame_byte %02h, want %02h",
							frame_byte, want.data));
					end
					if (last_byte !== want.last) begin
						report_mismatch($sformatf("last_byte %b, want %b",
							last_byte, want.last));
					end
				end
				bytes_seen++;
			end
			if (in_valid && in_ready) begin
				predict_attitude_frame(yaw_degrees, pitch_degrees);
			end
		end
		bytes_due <= due_bytes.size();
	end

endmodule

// ===== sim/tb_attitude_command_frame_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_attitude_command_frame_builder
// Feeds yaw / pitch pairs into the frame builder with random pacing on both
// channels; a checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_attitude_command_frame_builder;
	import acfb_pkg::*;

	typedef logic signed [AngleW-1:0] deg_t;

	// how often a side idles: never, now and then, or on almost every request
	typedef enum int {
		PACE_FULL,
		PACE_LIGHT,
		PACE_HEAVY
	} pace_t;

	localparam int PhaseCount     = 10;
	localparam int PhaseItems     = 43;
	localparam int LongHoldPhase  = 2;
	localparam int DrainPhase     = 6;
	localparam int LongHoldCycles = 400;
	// settle time after the final drain; a good margin past the pipeline
	localparam int SettleCycles   = 30;

	// extremes of both fields, the -360..360 edges, sign flips and
	// alternating bit patterns; everything outside -360..360 is still legal
	localparam int DirectedCount = 15;
	localparam int DirYaw   [DirectedCount] = '{
		0, 511, -512, 511, -512, 360, -360, 361, -361, 1, -1, 341, -342, 90, 100
	};
	localparam int DirPitch [DirectedCount] = '{
		0, 511, -512, -512, 511, -360, 360, -361, 361, -1, 1, -342, 341, 45, -100
	};

	logic clk;
	logic arst_n;

	acfb_in_if  in_ch ();
	acfb_out_if out_ch ();

	int    bytes_due;
	int    fail_count;
	pace_t source_pace   = PACE_LIGHT;
	pace_t sink_pace     = PACE_HEAVY;
	bit    long_hold_due = 1'b0;

	attitude_command_frame_builder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	attitude_frame_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.yaw_degrees   (in_ch.yaw_degrees),
		.pitch_degrees (in_ch.pitch_degrees),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.frame_byte    (out_ch.frame_byte),
		.last_byte     (out_ch.last_byte),
		.bytes_due     (bytes_due),
		.fail_count    (fail_count)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// single reset at the start
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard stop in case the block hangs; far above the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_attitude_command_frame_builder NOT OK");
		$finish;
	end

	// idle cycles before the next request on either side
	function automatic int pace_draw(input pace_t pace);
		case (pace)
			PACE_FULL:  return 0;
			PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
			default:    return $urandom_range(0, 16);
		endcase
	endfunction

	// mostly the full 10-bit range, some the usual -360..360, a few extremes
	function automatic deg_t random_angle();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0:       return deg_t'(-512);
					1:       return deg_t'(511);
					2:       return deg_t'(-360);
					3:       return deg_t'(360);
					default: return deg_t'(0);
				endcase
			end
			1, 2, 3: return deg_t'(int'($urandom_range(0, 720)) - 360);
			default: return deg_t'($urandom_range(0, 1023));
		endcase
	endfunction

	// offer one angle pair and return on the edge where the request is taken;
	// with no gap, valid simply stays high into the next request
	task automatic offer_angles(input deg_t yaw, input deg_t pitch, input int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.yaw_degrees   <= yaw;
		in_ch.pitch_degrees <= pitch;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// stop offering and wait until every predicted byte has been sent;
	// the extra edge lets the checker account for the last request first
	task automatic drain_frames();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		wait (bytes_due == 0);
		@(posedge clk);
	endtask

	// byte sink: random hold-offs per request, plus one long stall on demand
	// so the pipeline fills and the block has to drop in_ch.ready
	initial begin : byte_sink
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_due) begin
				out_ch.ready <= 1'b0;
				repeat (LongHoldCycles) @(posedge clk);
				long_hold_due = 1'b0;
			end
			stall = pace_draw(sink_pace);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	// angle source: directed pairs first, then random phases, then verdict
	initial begin : angle_source
		in_ch.valid         <= 1'b0;
		in_ch.yaw_degrees   <= '0;
		in_ch.pitch_degrees <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int i = 0; i < DirectedCount; i++) begin
			offer_angles(deg_t'(DirYaw[i]), deg_t'(DirPitch[i]), pace_draw(source_pace));
		end
		drain_frames();

		for (int phase = 0; phase < PhaseCount; phase++) begin
			if (phase == 0) begin
				// back to back on both sides: one request per frame time
				source_pace = PACE_FULL;
				sink_pace   = PACE_FULL;
			end else begin
				source_pace = pace_t'($urandom_range(0, 2));
				sink_pace   = pace_t'($urandom_range(0, 2));
			end
			if (phase == LongHoldPhase) begin
				// sender keeps pushing while the sink sits still
				source_pace   = PACE_FULL;
				long_hold_due = 1'b1;
			end
			if (phase == DrainPhase) begin
				drain_frames();
			end
			for (int i = 0; i < PhaseItems; i++) begin
				offer_angles(random_angle(), random_angle(), pace_draw(source_pace));
			end
		end

		drain_frames();
		// anything sent after this point has no frame due and fails the checker
		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_attitude_command_frame_builder OK");
		end else begin
			$display("tb_attitude_command_frame_builder NOT OK");
		end
		$finish;
	end

endmodule
